// ----- rtl/fodu_pkg.sv -----
// Package: widths, reset values and register indexes for the force oscillation detector.
package fodu_pkg;

    localparam int CFG_W    = 24;
    localparam int IDX_W    = 2;
    localparam int LOAD_W   = 24;
    localparam int TIME_W   = 48;
    localparam int LEVEL_W  = 33;
    localparam int INT_W    = 17;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 24;

    localparam int unsigned MAX_GAP_US = 100000;
    localparam int US_PER_S_W = 20;
    localparam logic [US_PER_S_W-1:0] US_PER_S = 20'd1000000;
    localparam logic [LEVEL_W-1:0] LEVEL_FULL = 33'h1_0000_0000;

    localparam logic [IDX_W-1:0] REG_RATE_THRESHOLD = 2'd0;
    localparam logic [IDX_W-1:0] REG_ATTACK_RATE    = 2'd1;
    localparam logic [IDX_W-1:0] REG_DECAY_RATE     = 2'd2;

    localparam logic [CFG_W-1:0] RST_RATE_THRESHOLD = 24'd5000;
    localparam logic [CFG_W-1:0] RST_ATTACK_RATE    = 24'd21475;
    localparam logic [CFG_W-1:0] RST_DECAY_RATE     = 24'd4295;

endpackage

// ----- rtl/force_oscillation_detector_unit.sv -----
// Top level: force oscillation detector, rate-threshold attack/decay intensity envelope.
//
//  channel | dir | handshake                      | payload
//  --------+-----+--------------------------------+-----------------------------------------
//  s_axis  | in  | s_axis_tvalid / s_axis_tready  | tdata: load_sample[23:0], time_us[71:24]
//          |     |                                | tuser: mode
//  m_axis  | out | m_axis_tvalid / m_axis_tready  | tdata: intensity[16:0], zeros[23:17]
//  cfg     | in  | i_cfg_we (no wait)             | i_cfg_idx, i_cfg_data
//
//  One request enters the input register, and its update then runs in one pass of logic
//  into the result register; one request per cycle sustained while m_axis does not stall.
//  The state loop (level, previous sample and time) closes in that single pass.
//  Reset is synchronous, active low; it clears state and loads the register defaults.
//  A stall at m_axis holds the result register, then the input register, then s_axis_tready.
module force_oscillation_detector_unit #(
    parameter int unsigned MAX_GAP_US = fodu_pkg::MAX_GAP_US
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // load_sample[23:0], time_us[71:24]
    input  logic [fodu_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // mode[0]
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // intensity[16:0], zero fill[23:17]
    output logic [fodu_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [fodu_pkg::IDX_W-1:0]          i_cfg_idx,
    input  logic [fodu_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int DT_W   = $clog2(MAX_GAP_US + 1);
    localparam int MAG_W  = fodu_pkg::LOAD_W + 1;
    localparam int LHS_W  = MAG_W + fodu_pkg::US_PER_S_W;
    localparam int RHS_W  = fodu_pkg::CFG_W + DT_W;
    localparam int PROD_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;
    localparam int STEP_W = fodu_pkg::CFG_W + DT_W;
    localparam int CMP_W  = (STEP_W > fodu_pkg::LEVEL_W) ? STEP_W : fodu_pkg::LEVEL_W;
    localparam int SUM_W  = CMP_W + 1;

    logic [fodu_pkg::CFG_W-1:0]   r_thr, r_attack, r_decay;

    logic                         r_in_valid;
    logic                         r_in_mode;
    logic [fodu_pkg::LOAD_W-1:0]  r_in_load;
    logic [fodu_pkg::TIME_W-1:0]  r_in_time;

    logic                         r_out_valid;
    logic [fodu_pkg::INT_W-1:0]   r_out_int;

    logic [fodu_pkg::LOAD_W-1:0]  r_prev_sample;
    logic [fodu_pkg::TIME_W-1:0]  r_prev_time;
    logic [fodu_pkg::LEVEL_W-1:0] r_level;
    logic                         r_primed;

    logic [fodu_pkg::LOAD_W-1:0]  n_prev_sample;
    logic [fodu_pkg::TIME_W-1:0]  n_prev_time;
    logic [fodu_pkg::LEVEL_W-1:0] n_level;
    logic                         n_primed;

    logic                         advance;
    logic [fodu_pkg::TIME_W-1:0]  dt_full;
    logic                         gap_ok;
    logic [DT_W-1:0]              dt;
    logic [MAG_W-1:0]             df;
    logic [MAG_W-1:0]             mag;
    logic [PROD_W-1:0]            lhs, rhs;
    logic [STEP_W-1:0]            up, down;
    logic [SUM_W-1:0]             sum;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(fodu_pkg::OUT_TDATA_W - fodu_pkg::INT_W){1'b0}}, r_out_int};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= fodu_pkg::RST_RATE_THRESHOLD;
            r_attack <= fodu_pkg::RST_ATTACK_RATE;
            r_decay  <= fodu_pkg::RST_DECAY_RATE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fodu_pkg::REG_RATE_THRESHOLD: r_thr    <= i_cfg_data;
                fodu_pkg::REG_ATTACK_RATE:    r_attack <= i_cfg_data;
                fodu_pkg::REG_DECAY_RATE:     r_decay  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        dt_full = r_in_time - r_prev_time;
        gap_ok  = (dt_full != '0) && (dt_full <= fodu_pkg::TIME_W'(MAX_GAP_US));
        dt      = dt_full[DT_W-1:0];
        df      = {r_in_load[fodu_pkg::LOAD_W-1], r_in_load}
                - {r_prev_sample[fodu_pkg::LOAD_W-1], r_prev_sample};
        mag     = df[MAG_W-1] ? (~df + MAG_W'(1)) : df;
        lhs     = PROD_W'(mag) * PROD_W'(fodu_pkg::US_PER_S);
        rhs     = PROD_W'(r_thr) * PROD_W'(dt);
        up      = STEP_W'(r_attack) * STEP_W'(dt);
        down    = STEP_W'(r_decay) * STEP_W'(dt);
        sum     = SUM_W'(r_level) + SUM_W'(up);

        n_prev_sample = r_prev_sample;
        n_prev_time   = r_prev_time;
        n_level       = r_level;
        n_primed      = r_primed;
        if (r_in_mode) begin
            n_prev_sample = '0;
            n_prev_time   = '0;
            n_level       = '0;
            n_primed      = 1'b0;
        end else if (!r_primed) begin
            n_prev_sample = r_in_load;
            n_prev_time   = r_in_time;
            n_primed      = 1'b1;
        end else begin
            n_prev_time = r_in_time;
            if (gap_ok) begin
                n_prev_sample = r_in_load;
                if (lhs > rhs) begin
                    n_level = (sum >= SUM_W'(fodu_pkg::LEVEL_FULL))
                            ? fodu_pkg::LEVEL_FULL : sum[fodu_pkg::LEVEL_W-1:0];
                end else begin
                    n_level = (CMP_W'(down) >= CMP_W'(r_level))
                            ? '0 : fodu_pkg::LEVEL_W'(CMP_W'(r_level) - CMP_W'(down));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_prev_sample <= '0;
            r_prev_time   <= '0;
            r_level       <= '0;
            r_primed      <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid   <= 1'b1;
                r_prev_sample <= n_prev_sample;
                r_prev_time   <= n_prev_time;
                r_level       <= n_level;
                r_primed      <= n_primed;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_mode <= s_axis_tuser;
            r_in_load <= s_axis_tdata[fodu_pkg::LOAD_W-1:0];
            r_in_time <= s_axis_tdata[fodu_pkg::LOAD_W +: fodu_pkg::TIME_W];
        end
        if (advance) begin
            r_out_int <= n_level[fodu_pkg::LEVEL_W-1 -: fodu_pkg::INT_W];
        end
    end

    a_level_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= fodu_pkg::LEVEL_FULL)
        else $error("level above full scale");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_mode |=> !r_primed && (r_level == '0) && (r_out_int == '0))
        else $error("restart left state behind");

    a_prime_holds_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !r_in_mode && !r_primed |=> r_primed && $stable(r_level))
        else $error("priming sample changed level");

    a_state_only_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_level) && $stable(r_prev_time) && $stable(r_primed))
        else $error("state moved without a request");

    a_advance_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("result lost");

endmodule

// ----- test/fodu_checker.sv -----
// Checker: watches the request, result and register ports and scores every intensity result.
module fodu_checker
    import fodu_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    // load_sample[23:0], time_us[71:24]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // mode[0]
    input  logic                   s_axis_tuser,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // intensity[16:0], zero fill[23:17]
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic [IDX_W-1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [CFG_W-1:0]         thr_mirror;
    logic [CFG_W-1:0]         attack_mirror;
    logic [CFG_W-1:0]         decay_mirror;
    logic signed [LOAD_W-1:0] last_load;
    logic [TIME_W-1:0]        last_stamp;
    logic [LEVEL_W-1:0]       envelope;
    logic                     primed;
    logic [INT_W-1:0]         intensity_q[$];

    function automatic logic [INT_W-1:0] step_envelope(
        input logic                     restart,
        input logic signed [LOAD_W-1:0] load,
        input logic [TIME_W-1:0]        stamp
    );
        logic [TIME_W-1:0]      dt;
        logic signed [LOAD_W:0] df;
        logic [63:0]            mag;
        logic [63:0]            up;
        logic [63:0]            down;
        if (restart) begin
            last_load  = '0;
            last_stamp = '0;
            envelope   = '0;
            primed     = 1'b0;
        end else if (!primed) begin
            last_load  = load;
            last_stamp = stamp;
            primed     = 1'b1;
        end else begin
            dt = stamp - last_stamp;
            last_stamp = stamp;
            if (dt != '0 && dt <= TIME_W'(MAX_GAP_US)) begin
                df = {load[LOAD_W-1], load} - {last_load[LOAD_W-1], last_load};
                if (df[LOAD_W]) begin
                    df = -df;
                end
                mag = 64'(unsigned'(df));
                last_load = load;
                if (mag * 64'(US_PER_S) > 64'(thr_mirror) * 64'(dt)) begin
                    up = 64'(attack_mirror) * 64'(dt);
                    if (up >= 64'(LEVEL_FULL) - 64'(envelope)) begin
                        envelope = LEVEL_FULL;
                    end else begin
                        envelope = envelope + up[LEVEL_W-1:0];
                    end
                end else begin
                    down = 64'(decay_mirror) * 64'(dt);
                    if (down >= 64'(envelope)) begin
                        envelope = '0;
                    end else begin
                        envelope = envelope - down[LEVEL_W-1:0];
                    end
                end
            end
        end
        return envelope[LEVEL_W-1:16];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            thr_mirror    = RST_RATE_THRESHOLD;
            attack_mirror = RST_ATTACK_RATE;
            decay_mirror  = RST_DECAY_RATE;
            last_load     = '0;
            last_stamp    = '0;
            envelope      = '0;
            primed        = 1'b0;
            intensity_q.delete();
            o_fail_count  = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (intensity_q.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("unexpected result: tdata %0h", m_axis_tdata);
                    end
                    o_fail_count++;
                end else if (m_axis_tdata != OUT_TDATA_W'(intensity_q[0])) begin
                    if (o_fail_count < 10) begin
                        $display("intensity mismatch: expected %0d got tdata %0h",
                                 intensity_q[0], m_axis_tdata);
                    end
                    o_fail_count++;
                    void'(intensity_q.pop_front());
                end else begin
                    void'(intensity_q.pop_front());
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                intensity_q.push_back(step_envelope(s_axis_tuser,
                                                    s_axis_tdata[LOAD_W-1:0],
                                                    s_axis_tdata[LOAD_W +: TIME_W]));
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_RATE_THRESHOLD: begin
                        thr_mirror = i_cfg_data;
                    end
                    REG_ATTACK_RATE: begin
                        attack_mirror = i_cfg_data;
                    end
                    REG_DECAY_RATE: begin
                        decay_mirror = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending = intensity_q.size();
    end

endmodule

// ----- test/tb_top.sv -----
// Testbench top: clock, reset, request and register stimulus, result back-pressure and verdict.
module tb_top;
    import fodu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic MODE_SAMPLE  = 1'b0;
    localparam logic MODE_RESTART = 1'b1;
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [CFG_W-1:0] CFG_MAX    = 24'hFF_FFFF;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we = 1'b0;
    logic [IDX_W-1:0]       i_cfg_idx = '0;
    logic [CFG_W-1:0]       i_cfg_data = '0;
    int                     fail_count;
    int                     pending;

    bit                     no_gaps = 1'b0;
    bit                     hold_rx = 1'b0;
    int                     rx_stall = 0;
    logic [TIME_W-1:0]      stamp_now = '0;
    longint                 load_now = 0;
    bit                     armed = 1'b0;
    logic [CFG_W-1:0]       thr_now = RST_RATE_THRESHOLD;

    force_oscillation_detector_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    fodu_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 2);
        end else if (r < 95) begin
            return $urandom_range(3, 8);
        end
        return $urandom_range(20, 80);
    endfunction

    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_rx) begin
                m_axis_tready = 1'b0;
                repeat (400) @(negedge i_clk);
                hold_rx = 1'b0;
            end else if (rx_stall > 0) begin
                m_axis_tready = 1'b0;
                rx_stall--;
            end else begin
                m_axis_tready = 1'b1;
                if (!no_gaps && $urandom_range(0, 99) < 20) begin
                    rx_stall = idle_len();
                end
            end
        end
    end

    task automatic send_item(input logic mode, input logic [LOAD_W-1:0] load,
                             input logic [TIME_W-1:0] stamp);
        int                gap;
        logic [TIME_W-1:0] dt;
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = mode;
        s_axis_tdata  = {stamp, load};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        dt = stamp - stamp_now;
        if (mode == MODE_RESTART) begin
            armed = 1'b0;
        end else begin
            if (!armed || (dt != '0 && dt <= TIME_W'(MAX_GAP_US))) begin
                load_now = longint'(signed'(load));
            end
            armed     = 1'b1;
            stamp_now = stamp;
        end
        gap = (!no_gaps && $urandom_range(0, 99) < 35) ? idle_len() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        drain();
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        if (idx == REG_RATE_THRESHOLD) begin
            thr_now = data;
        end
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic load_setting(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] atk,
                                input logic [CFG_W-1:0] dec);
        write_reg(REG_RATE_THRESHOLD, thr);
        write_reg(REG_ATTACK_RATE, atk);
        write_reg(REG_DECAY_RATE, dec);
    endtask

    task automatic random_burst(input int count, input int hold_at);
        int                r;
        int                q;
        longint            mag;
        longint            step;
        longint            next_load;
        logic [TIME_W-1:0] dt;
        for (int n = 0; n < count; n++) begin
            if (n == hold_at) begin
                hold_rx = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 3) begin
                send_item(MODE_RESTART, LOAD_W'($urandom), TIME_W'({$urandom, $urandom}));
            end else if (r < 10) begin
                send_item(MODE_SAMPLE, LOAD_W'($urandom), TIME_W'({$urandom, $urandom}));
            end else begin
                q = $urandom_range(0, 99);
                if (q < 4) begin
                    dt = '0;
                end else if (q < 8) begin
                    dt = TIME_W'(MAX_GAP_US) + TIME_W'($urandom_range(0, 1));
                end else if (q < 10) begin
                    dt = TIME_W'({$urandom, $urandom});
                end else if (q < 50) begin
                    dt = TIME_W'($urandom_range(1, 200));
                end else if (q < 85) begin
                    dt = TIME_W'($urandom_range(200, 5000));
                end else begin
                    dt = TIME_W'($urandom_range(5000, MAX_GAP_US));
                end
                q = $urandom_range(0, 99);
                if (q < 40) begin
                    mag = (longint'(thr_now) * longint'(dt[19:0])) / 1000000
                          + longint'($urandom_range(0, 2)) - 1;
                    if (mag < 0) begin
                        mag = 0;
                    end
                end else if (q < 70) begin
                    mag = longint'($urandom_range(0, 200));
                end else begin
                    mag = longint'($urandom_range(0, 24'hFF_FFFF));
                end
                step = $urandom_range(0, 1) ? mag : -mag;
                next_load = load_now + step;
                if (next_load > 8388607 || next_load < -8388608) begin
                    next_load = load_now - step;
                end
                if (next_load > 8388607) begin
                    next_load = 8388607;
                end else if (next_load < -8388608) begin
                    next_load = -8388608;
                end
                send_item(MODE_SAMPLE, next_load[LOAD_W-1:0], stamp_now + dt);
            end
        end
    endtask

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // prime at timestamp zero, then extreme swing, zero gap, longest gap and over-long gap
        send_item(MODE_SAMPLE, 24'h80_0000, 48'd0);
        send_item(MODE_SAMPLE, 24'h7F_FFFF, 48'd1);
        send_item(MODE_SAMPLE, 24'h00_0000, 48'd1);
        send_item(MODE_SAMPLE, 24'h7F_FFFF, 48'd100001);
        send_item(MODE_SAMPLE, 24'h00_0000, 48'd200002);
        // timestamp going backwards
        send_item(MODE_SAMPLE, 24'h00_0000, 48'd50);
        // rate exactly on the threshold, then just above it
        send_item(MODE_SAMPLE, 24'h7F_FFFE, 48'd250);
        send_item(MODE_SAMPLE, 24'h7F_FFFC, 48'd450);
        // restart with junk fields, prime at the top of the counter, then wrap
        send_item(MODE_RESTART, 24'hFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_item(MODE_SAMPLE, 24'h00_0000, 48'hFFFF_FFFF_FFFF);
        send_item(MODE_SAMPLE, 24'd5000, 48'd5);
        load_setting('0, CFG_MAX, '0);
        send_item(MODE_SAMPLE, 24'd5000, 48'd6);
        send_item(MODE_SAMPLE, 24'h80_0000, 48'd1006);
        send_item(MODE_SAMPLE, 24'h7F_FFFF, 48'd2006);
        load_setting(CFG_MAX, CFG_MAX, CFG_MAX);
        send_item(MODE_SAMPLE, 24'h7F_FFFF, 48'd3006);
        write_reg(REG_UNUSED, CFG_W'($urandom));
        send_item(MODE_SAMPLE, 24'h00_0000, 48'd3106);
        send_item(MODE_RESTART, 24'h00_0000, 48'd0);
        send_item(MODE_SAMPLE, 24'h12_3456, 48'd0);
        send_item(MODE_SAMPLE, 24'hED_CBAA, 48'd7);

        load_setting(RST_RATE_THRESHOLD, RST_ATTACK_RATE, RST_DECAY_RATE);
        random_burst(200, -1);

        load_setting('0, CFG_MAX, '0);
        stamp_now = 48'hFFFF_FFFF_FFFF - TIME_W'($urandom_range(0, 50000));
        no_gaps = 1'b1;
        random_burst(180, -1);
        no_gaps = 1'b0;

        load_setting(CFG_MAX, '0, CFG_MAX);
        random_burst(180, 60);

        load_setting(CFG_W'($urandom_range(0, 20000)), CFG_W'($urandom_range(0, 200000)),
                     CFG_W'($urandom_range(0, 50000)));
        random_burst(100, -1);
        drain();
        random_burst(100, -1);

        load_setting(CFG_W'($urandom_range(0, 20000)), CFG_W'($urandom_range(0, 200000)),
                     CFG_W'($urandom_range(0, 50000)));
        random_burst(230, 120);

        load_setting(CFG_W'($urandom_range(1000, 100000)), CFG_W'($urandom_range(0, 50000)),
                     CFG_W'($urandom_range(0, 200000)));
        random_burst(230, -1);

        drain();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/fodu_pkg.sv
rtl/force_oscillation_detector_unit.sv
test/fodu_checker.sv
test/tb_top.sv
